### rtl/fowm_pkg.sv
// ----------------------------------------------------------------------------
// fowm_pkg
// Shared sizes and codes for the FIFO occupancy and wait monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fowm_pkg;

    localparam int DEPTH       = 64;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam int TIME_W      = 32;
    localparam int ID_W        = 16;
    localparam int ENTRY_W     = ID_W + TIME_W;

    localparam int INTEG_W     = 40;
    localparam int WAIT_W      = 48;
    localparam int SERVED_W    = 32;
    localparam int FRAC_W      = 8;
    localparam int LEN_OUT_W   = 7;
    localparam int AVG_LEN_W   = 15;
    localparam int AVG_WAIT_W  = 40;

    localparam int PROD_W      = CNT_W + TIME_W;
    localparam int INTEG_SUM_W = ((INTEG_W > PROD_W) ? INTEG_W : PROD_W) + 1;
    localparam int WAIT_SUM_W  = WAIT_W + 1;

    // shared serial divider sizing
    localparam int DIVIDEND_W  = WAIT_W + FRAC_W;
    localparam int DIVISOR_W   = 32;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

    localparam logic [1:0] CMD_ADD       = 2'd0;
    localparam logic [1:0] CMD_REMOVE    = 2'd1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

endpackage

`default_nettype wire

### rtl/fowm_div.sv
// ----------------------------------------------------------------------------
// fowm_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fowm_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [fowm_pkg::DIVIDEND_W-1:0]   dividend,
    input  wire logic [fowm_pkg::DIVISOR_W-1:0]    divisor,
    output logic                                   done,
    output logic [fowm_pkg::DIVIDEND_W-1:0]        quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [fowm_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [fowm_pkg::DIVIDEND_W-1:0]    quo_reg;
    logic [fowm_pkg::DIVISOR_W-1:0]     rem_reg;
    logic [fowm_pkg::DIVISOR_W-1:0]     dvsr_reg;

    logic [fowm_pkg::DIVISOR_W:0]       rem_shift;
    logic                               ge;
    logic [fowm_pkg::DIVISOR_W:0]       rem_diff;
    logic [fowm_pkg::DIVISOR_W-1:0]     rem_next;
    logic [fowm_pkg::DIVIDEND_W-1:0]    quo_next;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[fowm_pkg::DIVIDEND_W-1]};
        ge        = rem_shift >= {1'b0, dvsr_reg};
        rem_diff  = rem_shift - {1'b0, dvsr_reg};
        rem_next  = ge ? rem_diff[fowm_pkg::DIVISOR_W-1:0]
                       : rem_shift[fowm_pkg::DIVISOR_W-1:0];
        quo_next  = {quo_reg[fowm_pkg::DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= fowm_pkg::DIV_CNT_W'(fowm_pkg::DIVIDEND_W);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvsr_reg <= divisor;
            end else if (busy_reg) begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == fowm_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/fifo_occupancy_and_wait_monitor.sv
// ----------------------------------------------------------------------------
// fifo_occupancy_and_wait_monitor
// FIFO of client entries with occupancy and waiting-time statistics.
// ----------------------------------------------------------------------------
// Each command (add, remove, query) produces one result: status, the removed
// entry, empty flag, length, peak length, and the average length and average
// wait in Q8. A command steps through multiply, integrate and update, then
// waits on the two 56-step serial dividers that run side by side for the
// averages; a new command is accepted only in the cycle after the result
// is loaded for the m_ side. Entries sit in one 48-bit wide synchronous RAM
// read at the head when a command is accepted. A new command is accepted
// while the previous result is still waiting on the m_ side; its own
// result then waits in the last stage until that earlier result is taken.
`timescale 1ns / 1ps
`default_nettype none

module fifo_occupancy_and_wait_monitor (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_cmd,
    input  wire logic [31:0]  s_now,
    input  wire logic [15:0]  s_client_id,
    input  wire logic [31:0]  s_arrival_time,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [1:0]        m_status,
    output logic [15:0]       m_out_client_id,
    output logic [31:0]       m_out_arrival_time,
    output logic              m_is_empty,
    output logic [6:0]        m_queue_length,
    output logic [6:0]        m_max_length,
    output logic [14:0]       m_avg_length_q8,
    output logic [39:0]       m_avg_wait_q8
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INTEG,
        ST_UPDATE,
        ST_DIV,
        ST_WAIT,
        ST_OUT
    } state_t;

    function automatic logic [fowm_pkg::PTR_W-1:0] next_ptr(
        input logic [fowm_pkg::PTR_W-1:0] p
    );
        logic [fowm_pkg::PTR_W-1:0] r;
        if (p == fowm_pkg::PTR_W'(fowm_pkg::DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // entry store: {client id, arrival time}
    logic [fowm_pkg::ENTRY_W-1:0]     mem [fowm_pkg::DEPTH];
    logic [fowm_pkg::ENTRY_W-1:0]     rd_data_reg;
    logic                             mem_we;

    state_t                           state_reg;
    logic                             m_valid_reg;

    logic [fowm_pkg::PTR_W-1:0]       head_ptr_reg;
    logic [fowm_pkg::PTR_W-1:0]       tail_ptr_reg;
    logic [fowm_pkg::CNT_W-1:0]       count_reg;
    logic [fowm_pkg::CNT_W-1:0]       peak_reg;
    logic [fowm_pkg::TIME_W-1:0]      last_update_reg;
    logic [fowm_pkg::INTEG_W-1:0]     integral_reg;
    logic [fowm_pkg::WAIT_W-1:0]      total_wait_reg;
    logic [fowm_pkg::SERVED_W-1:0]    served_reg;

    logic [1:0]                       cmd_reg;
    logic [fowm_pkg::TIME_W-1:0]      now_reg;
    logic [fowm_pkg::ID_W-1:0]        cid_reg;
    logic [fowm_pkg::TIME_W-1:0]      arr_reg;
    logic [fowm_pkg::TIME_W-1:0]      elapsed_reg;
    logic [fowm_pkg::PROD_W-1:0]      prod_reg;
    logic [1:0]                       status_reg;
    logic [fowm_pkg::ID_W-1:0]        rid_reg;
    logic [fowm_pkg::TIME_W-1:0]      rarr_reg;

    logic [1:0]                       m_status_reg;
    logic [fowm_pkg::ID_W-1:0]        m_cid_reg;
    logic [fowm_pkg::TIME_W-1:0]      m_arr_reg;
    logic                             m_empty_reg;
    logic [fowm_pkg::LEN_OUT_W-1:0]   m_len_reg;
    logic [fowm_pkg::LEN_OUT_W-1:0]   m_peak_reg;
    logic [fowm_pkg::AVG_LEN_W-1:0]   m_avg_len_reg;
    logic [fowm_pkg::AVG_WAIT_W-1:0]  m_avg_wait_reg;

    logic                             accept;
    logic [fowm_pkg::TIME_W-1:0]      elapsed_next;
    logic [fowm_pkg::INTEG_SUM_W-1:0] integ_sum;
    logic [fowm_pkg::INTEG_W-1:0]     integral_next;
    logic [fowm_pkg::ID_W-1:0]        rd_id;
    logic [fowm_pkg::TIME_W-1:0]      rd_arr;
    logic [fowm_pkg::TIME_W-1:0]      wait_amt;
    logic [fowm_pkg::WAIT_SUM_W-1:0]  wait_sum;
    logic [fowm_pkg::WAIT_W-1:0]      total_wait_next;
    logic [fowm_pkg::SERVED_W-1:0]    served_next;
    logic [fowm_pkg::CNT_W-1:0]       count_inc;
    logic                             is_full;
    logic                             is_empty;

    logic                             div_start;
    logic                             len_done;
    logic                             wait_done;
    logic [fowm_pkg::DIVIDEND_W-1:0]  len_quo;
    logic [fowm_pkg::DIVIDEND_W-1:0]  wait_quo;
    logic [fowm_pkg::AVG_LEN_W-1:0]   avg_len_next;
    logic [fowm_pkg::AVG_WAIT_W-1:0]  avg_wait_next;
    logic                             out_load;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        elapsed_next = (s_now >= last_update_reg) ? (s_now - last_update_reg) : '0;

        integ_sum     = fowm_pkg::INTEG_SUM_W'(integral_reg)
                      + fowm_pkg::INTEG_SUM_W'(prod_reg);
        integral_next = (|integ_sum[fowm_pkg::INTEG_SUM_W-1:fowm_pkg::INTEG_W])
                      ? '1 : integ_sum[fowm_pkg::INTEG_W-1:0];

        rd_id    = rd_data_reg[fowm_pkg::ENTRY_W-1:fowm_pkg::TIME_W];
        rd_arr   = rd_data_reg[fowm_pkg::TIME_W-1:0];
        wait_amt = (now_reg >= rd_arr) ? (now_reg - rd_arr) : '0;
        wait_sum = {1'b0, total_wait_reg} + fowm_pkg::WAIT_SUM_W'(wait_amt);
        total_wait_next = wait_sum[fowm_pkg::WAIT_W] ? '1
                        : wait_sum[fowm_pkg::WAIT_W-1:0];
        served_next = (&served_reg) ? served_reg : served_reg + 1'b1;

        count_inc = count_reg + 1'b1;
        is_full   = (count_reg == fowm_pkg::CNT_W'(fowm_pkg::DEPTH));
        is_empty  = (count_reg == '0);
    end

    assign mem_we    = (state_reg == ST_UPDATE) && (cmd_reg == fowm_pkg::CMD_ADD) && !is_full;
    assign div_start = (state_reg == ST_DIV);
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[tail_ptr_reg] <= {cid_reg, arr_reg};
        end
        if (accept) begin
            rd_data_reg <= mem[head_ptr_reg];
        end
    end

    fowm_div u_len_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (fowm_pkg::DIVIDEND_W'({integral_reg, fowm_pkg::FRAC_W'(0)})),
        .divisor  (fowm_pkg::DIVISOR_W'(now_reg)),
        .done     (len_done),
        .quotient (len_quo)
    );

    fowm_div u_wait_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (fowm_pkg::DIVIDEND_W'({total_wait_reg, fowm_pkg::FRAC_W'(0)})),
        .divisor  (fowm_pkg::DIVISOR_W'(served_reg)),
        .done     (wait_done),
        .quotient (wait_quo)
    );

    // zero divisor gives 0; oversized quotients clamp
    always_comb begin
        if (now_reg == '0) begin
            avg_len_next = '0;
        end else if (|len_quo[fowm_pkg::DIVIDEND_W-1:fowm_pkg::AVG_LEN_W]) begin
            avg_len_next = '1;
        end else begin
            avg_len_next = len_quo[fowm_pkg::AVG_LEN_W-1:0];
        end
        if (served_reg == '0) begin
            avg_wait_next = '0;
        end else if (|wait_quo[fowm_pkg::DIVIDEND_W-1:fowm_pkg::AVG_WAIT_W]) begin
            avg_wait_next = '1;
        end else begin
            avg_wait_next = wait_quo[fowm_pkg::AVG_WAIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            head_ptr_reg    <= '0;
            tail_ptr_reg    <= '0;
            count_reg       <= '0;
            peak_reg        <= '0;
            last_update_reg <= '0;
            integral_reg    <= '0;
            total_wait_reg  <= '0;
            served_reg      <= '0;
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg     <= s_cmd;
                        now_reg     <= s_now;
                        cid_reg     <= s_client_id;
                        arr_reg     <= s_arrival_time;
                        elapsed_reg <= elapsed_next;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= fowm_pkg::PROD_W'(count_reg)
                               * fowm_pkg::PROD_W'(elapsed_reg);
                    state_reg <= ST_INTEG;
                end
                ST_INTEG: begin
                    integral_reg    <= integral_next;
                    last_update_reg <= now_reg;
                    state_reg       <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    status_reg <= fowm_pkg::STATUS_OK;
                    rid_reg    <= '0;
                    rarr_reg   <= '0;
                    priority if (cmd_reg == fowm_pkg::CMD_ADD) begin
                        if (is_full) begin
                            status_reg <= fowm_pkg::STATUS_FULL;
                        end else begin
                            tail_ptr_reg <= next_ptr(tail_ptr_reg);
                            count_reg    <= count_inc;
                            if (count_inc > peak_reg) begin
                                peak_reg <= count_inc;
                            end
                        end
                    end else if (cmd_reg == fowm_pkg::CMD_REMOVE) begin
                        if (is_empty) begin
                            status_reg <= fowm_pkg::STATUS_EMPTY;
                        end else begin
                            rid_reg        <= rd_id;
                            rarr_reg       <= rd_arr;
                            head_ptr_reg   <= next_ptr(head_ptr_reg);
                            count_reg      <= count_reg - 1'b1;
                            total_wait_reg <= total_wait_next;
                            served_reg     <= served_next;
                        end
                    end else begin
                        // query and unused code: statistics only
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (len_done && wait_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_valid_reg    <= 1'b1;
                        m_status_reg   <= status_reg;
                        m_cid_reg      <= rid_reg;
                        m_arr_reg      <= rarr_reg;
                        m_empty_reg    <= is_empty;
                        m_len_reg      <= fowm_pkg::LEN_OUT_W'(count_reg);
                        m_peak_reg     <= fowm_pkg::LEN_OUT_W'(peak_reg);
                        m_avg_len_reg  <= avg_len_next;
                        m_avg_wait_reg <= avg_wait_next;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_out_client_id    = m_cid_reg;
    assign m_out_arrival_time = m_arr_reg;
    assign m_is_empty         = m_empty_reg;
    assign m_queue_length     = m_len_reg;
    assign m_max_length       = m_peak_reg;
    assign m_avg_length_q8    = m_avg_len_reg;
    assign m_avg_wait_q8      = m_avg_wait_reg;

endmodule

`default_nettype wire
